[hw/rtl/psrl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and codes of the profiling sample ring logger
// Command, status and counter codes; payload and front-to-back structs.
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam logic [2:0] CMD_LOG   = 3'd0;
  localparam logic [2:0] CMD_TRACE = 3'd1;
  localparam logic [2:0] CMD_TAIL  = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_STAT  = 3'd4;
  localparam logic [2:0] CMD_RESET = 3'd5;
  localparam logic [2:0] CMD_CLEAR = 3'd6;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_UNPROF  = 3'd1;
  localparam logic [2:0] ST_NOBUF   = 3'd2;
  localparam logic [2:0] ST_LOST    = 3'd3;
  localparam logic [2:0] ST_CORRUPT = 3'd4;
  localparam logic [2:0] ST_BADPC   = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  localparam logic [2:0] G_TOTAL   = 3'd0;
  localparam logic [2:0] G_OTHERS  = 3'd1;
  localparam logic [2:0] G_INVALID = 3'd2;
  localparam logic [2:0] G_CORRUPT = 3'd3;
  localparam logic [2:0] G_LOST    = 3'd4;
  localparam logic [2:0] G_ACTIVE  = 3'd5;
  localparam logic [2:0] G_PASSIVE = 3'd6;

  localparam logic [2:0] REG_RING_SIZE  = 3'd0;
  localparam logic [2:0] REG_BACKTRACE  = 3'd1;
  localparam logic [2:0] REG_ESCAPE     = 3'd2;
  localparam logic [2:0] REG_BEGIN_CODE = 3'd3;
  localparam logic [2:0] REG_PROFILED   = 3'd4;
  localparam logic [2:0] REG_ACTIVE     = 3'd5;
  localparam logic [2:0] REG_PRESENT    = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  buffer_sel;
    logic [63:0] sample_pc;
    logic [1:0]  sample_mode;
    logic [7:0]  sample_event;
    logic [7:0]  tail_value;
    logic [7:0]  entry_index;
    logic [3:0]  stat_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  entries_written;
    logic [7:0]  head_now;
    logic [63:0] read_pc;
    logic [1:0]  read_mode;
    logic [7:0]  read_event;
    logic [63:0] stat_value;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  buffer_sel;
    logic        in_range;
    logic        present;
    logic        profiled;
    logic        active;
    logic        bad_pc;
    logic [63:0] sample_pc;
    logic [1:0]  sample_mode;
    logic [7:0]  sample_event;
    logic [7:0]  tail_value;
    logic [7:0]  entry_index;
    logic [3:0]  stat_select;
  } task_t;

endpackage
`default_nettype wire

[hw/rtl/psrl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_front: command classifier
// Decodes buffer presence and mask bits, checks the escape pc, and pushes
// the classified command into a two-entry queue.
// ----------------------------------------------------------------------------
module psrl_front #(
  parameter int NUM_BUFFERS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire psrl_pkg::in_item_t in_item,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [63:0]        escape_value,
  input  wire logic [7:0]         profiled_mask,
  input  wire logic [7:0]         active_mask,
  input  wire logic [7:0]         present_mask,
  output psrl_pkg::task_t         q_task,
  output logic                    q_valid,
  input  wire logic               q_pop
);
  import psrl_pkg::*;

  task_t      slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  task_t      cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.command      = in_item.command;
    cls.buffer_sel   = in_item.buffer_sel;
    cls.in_range     = 32'(in_item.buffer_sel) < NUM_BUFFERS;
    cls.present      = cls.in_range && present_mask[in_item.buffer_sel];
    cls.profiled     = profiled_mask[in_item.buffer_sel];
    cls.active       = active_mask[in_item.buffer_sel];
    cls.bad_pc       = in_item.sample_pc == escape_value;
    cls.sample_pc    = in_item.sample_pc;
    cls.sample_mode  = in_item.sample_mode;
    cls.sample_event = in_item.sample_event;
    cls.tail_value   = in_item.tail_value;
    cls.entry_index  = in_item.entry_index;
    cls.stat_select  = in_item.stat_select;
  end

  assign in_full = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign q_task  = slot[rd_ptr];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cls;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/psrl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_back: ring and counter executor
// Runs one classified command through a small sequencer: ring writes,
// head and counter updates, entry reads, and result delivery.
// ----------------------------------------------------------------------------
module psrl_back #(
  parameter int NUM_BUFFERS = 8,
  parameter int RING_DEPTH  = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire psrl_pkg::task_t     q_task,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire logic [8:0]          ring_size,
  input  wire logic                backtrace_on,
  input  wire logic [63:0]         escape_value,
  input  wire logic [7:0]          trace_begin_code,
  output psrl_pkg::out_item_t      out_item,
  output logic                     out_empty,
  input  wire logic                out_pop
);
  import psrl_pkg::*;

  localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int EW = $clog2(RING_DEPTH);
  localparam int MD = NUM_BUFFERS * RING_DEPTH;
  localparam int AW = $clog2(MD);
  localparam int NBC = NUM_BUFFERS * 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WR2   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state;
  task_t       cur;
  logic [7:0]  head [NUM_BUFFERS];
  logic [7:0]  tail [NUM_BUFFERS];
  logic [63:0] gcnt [8];
  logic [31:0] bcnt [NBC];
  logic [63:0] mem_pc [MD];
  logic [9:0]  mem_me [MD];
  logic [63:0] rd_pc;
  logic [9:0]  rd_me;
  out_item_t   res;
  logic        res_full;

  logic [BW-1:0] bi;
  logic [8:0]    esize;
  logic [8:0]    h9, t9, hn1;
  logic [9:0]    freesp;
  logic          corrupt;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   wr_pc;
  logic [9:0]    wr_me;
  logic [1:0]    bsel;

  assign bi     = cur.buffer_sel[BW-1:0];
  assign esize  = (32'(ring_size) > RING_DEPTH) ? 9'(RING_DEPTH) : ring_size;
  assign h9     = cur.in_range ? {1'b0, head[bi]} : 9'd0;
  assign t9     = cur.in_range ? {1'b0, tail[bi]} : 9'd0;
  assign corrupt = (h9 >= esize) || (t9 >= esize);
  assign freesp = ((t9 > h9) ? 10'd0 : {1'b0, esize}) + {1'b0, t9} - {1'b0, h9} - 10'd1;
  assign hn1    = (h9 + 9'd1 >= esize) ? 9'd0 : h9 + 9'd1;
  assign bsel   = (cur.sample_mode == 2'd0) ? 2'd1 : (cur.sample_mode == 2'd1) ? 2'd2 : 2'd3;

  // Take a new command only once the result register is free or leaving.
  assign q_pop     = (state == S_IDLE) && q_valid && (!res_full || out_pop);
  assign out_empty = !res_full;
  assign out_item  = res;

  // Write port address and data, chosen per sequencer step.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'({bi, EW'(0)}) | AW'(h9);
    wr_pc   = cur.sample_pc;
    wr_me   = {cur.sample_mode, cur.sample_event};
    rd_addr = AW'({bi, EW'(0)}) | AW'(cur.entry_index);
    if (state == S_EXEC && cur.present && !corrupt) begin
      if (cur.command == CMD_LOG && cur.profiled) begin
        if (backtrace_on) begin
          wr_en = freesp[9] == 1'b0 && freesp >= 10'd2;
          wr_pc = escape_value;
          wr_me = {cur.sample_mode, trace_begin_code};
        end else begin
          wr_en = !freesp[9] && freesp != 10'd0;
        end
      end else if (cur.command == CMD_TRACE && !cur.bad_pc) begin
        wr_en = !freesp[9] && freesp != 10'd0;
        wr_me = {cur.sample_mode, 8'd0};
      end
    end else if (state == S_WR2) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_pc[wr_addr] <= wr_pc;
      mem_me[wr_addr] <= wr_me;
    end
    rd_pc <= mem_pc[rd_addr];
    rd_me <= mem_me[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_task;
    if (rst) begin
      state    <= S_IDLE;
      res_full <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        head[i] <= 8'd0;
        tail[i] <= 8'd0;
      end
      for (int i = 0; i < 8; i++) gcnt[i] <= 64'd0;
      for (int i = 0; i < NBC; i++) bcnt[i] <= 32'd0;
    end else begin
      if (out_pop && res_full) res_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) state <= S_EXEC;
        end
        S_EXEC: begin
          res            <= '0;
          res.status     <= ST_DONE;
          res.head_now   <= h9[7:0];
          state          <= S_OUT;
          case (cur.command)
            CMD_LOG: begin
              gcnt[G_TOTAL] <= gcnt[G_TOTAL] + 64'd1;
              if (!cur.profiled) begin
                gcnt[G_OTHERS] <= gcnt[G_OTHERS] + 64'd1;
                res.status <= ST_UNPROF;
              end else if (!cur.present) begin
                gcnt[G_INVALID] <= gcnt[G_INVALID] + 64'd1;
                res.status <= ST_NOBUF;
              end else if (backtrace_on && (freesp[9] || freesp < 10'd2) && !corrupt) begin
                bcnt[{bi, 2'd0}] <= bcnt[{bi, 2'd0}] + 32'd1;
                gcnt[G_LOST] <= gcnt[G_LOST] + 64'd1;
                res.status <= ST_LOST;
              end else if (corrupt) begin
                // Backtrace without two computed free slots is plain lost;
                // otherwise count corruption, and lost as well under backtrace.
                if (backtrace_on) begin
                  bcnt[{bi, 2'd0}] <= bcnt[{bi, 2'd0}] + 32'd1;
                  gcnt[G_LOST] <= gcnt[G_LOST] + 64'd1;
                end
                if (backtrace_on && (freesp[9] || freesp < 10'd2)) begin
                  res.status <= ST_LOST;
                end else begin
                  gcnt[G_CORRUPT] <= gcnt[G_CORRUPT] + 64'd1;
                  res.status <= ST_CORRUPT;
                end
              end else if (!backtrace_on && freesp == 10'd0) begin
                bcnt[{bi, 2'd0}] <= bcnt[{bi, 2'd0}] + 32'd1;
                gcnt[G_LOST] <= gcnt[G_LOST] + 64'd1;
                res.status <= ST_LOST;
              end else begin
                if (cur.active) gcnt[G_ACTIVE] <= gcnt[G_ACTIVE] + 64'd1;
                else gcnt[G_PASSIVE] <= gcnt[G_PASSIVE] + 64'd1;
                bcnt[{bi, bsel}] <= bcnt[{bi, bsel}] + 32'd1;
                res.status <= ST_STORED;
                if (backtrace_on) begin
                  head[bi] <= hn1[7:0];
                  state    <= S_WR2;
                end else begin
                  head[bi] <= hn1[7:0];
                  res.entries_written <= 2'd1;
                  res.head_now        <= hn1[7:0];
                end
              end
            end
            CMD_TRACE: begin
              if (cur.bad_pc) begin
                gcnt[G_INVALID] <= gcnt[G_INVALID] + 64'd1;
                res.status <= ST_BADPC;
              end else if (!cur.present) begin
                gcnt[G_INVALID] <= gcnt[G_INVALID] + 64'd1;
                res.status <= ST_NOBUF;
              end else if (corrupt) begin
                gcnt[G_CORRUPT] <= gcnt[G_CORRUPT] + 64'd1;
                res.status <= ST_CORRUPT;
              end else if (freesp == 10'd0) begin
                bcnt[{bi, 2'd0}] <= bcnt[{bi, 2'd0}] + 32'd1;
                gcnt[G_LOST] <= gcnt[G_LOST] + 64'd1;
                res.status <= ST_LOST;
              end else begin
                head[bi] <= hn1[7:0];
                res.status          <= ST_STORED;
                res.entries_written <= 2'd1;
                res.head_now        <= hn1[7:0];
              end
            end
            CMD_TAIL: begin
              if (cur.in_range) tail[bi] <= cur.tail_value;
              else res.status <= ST_NOBUF;
            end
            CMD_READ: begin
              if (!cur.in_range) res.status <= ST_NOBUF;
              else if (32'(cur.entry_index) < RING_DEPTH) state <= S_READ;
            end
            CMD_STAT: begin
              if (!cur.stat_select[3]) res.stat_value <= gcnt[cur.stat_select[2:0]];
              else if (!cur.stat_select[2] && cur.in_range)
                res.stat_value <= {32'd0, bcnt[{bi, cur.stat_select[1:0]}]};
            end
            CMD_RESET: begin
              if (cur.in_range) begin
                head[bi] <= 8'd0;
                tail[bi] <= 8'd0;
                res.head_now <= 8'd0;
              end else begin
                res.status <= ST_NOBUF;
              end
            end
            CMD_CLEAR: begin
              for (int i = 0; i < 8; i++) gcnt[i] <= 64'd0;
            end
            default: begin
            end
          endcase
        end
        S_WR2: begin
          // Second write of the marker pair: the sample itself.
          head[bi]            <= hn1[7:0];
          res.entries_written <= 2'd2;
          res.head_now        <= hn1[7:0];
          state               <= S_OUT;
        end
        S_READ: begin
          res.read_pc    <= rd_pc;
          res.read_mode  <= rd_me[9:8];
          res.read_event <= rd_me[7:0];
          state          <= S_OUT;
        end
        S_OUT: begin
          // The result register is free here: the command was only popped then.
          res_full <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/profile_sample_ring_logger.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// profile_sample_ring_logger: profiling sample ring logger
// Logs pc/mode/event samples into per-buffer circular rings and keeps
// global and per-buffer counters; commands manage tails, reads and stats.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | push / full        | in_item   (psrl_pkg::in_item_t)
//  result   | pop / empty        | out_item  (psrl_pkg::out_item_t)
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A command passes through the back-end sequencer steps pop, execute and
// deliver; a backtrace pair or an entry read adds one step: the second ring
// write or the registered ring memory read.
// Reset is synchronous; heads, tails and counters clear at once, the ring
// memory is not cleared. The back end pops the next command only while the
// result register is free or being drained; the two-entry queue accepts
// commands until it fills while the back end stalls on a full result register.
module profile_sample_ring_logger #(
  parameter int NUM_BUFFERS = 8,
  parameter int RING_DEPTH  = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire psrl_pkg::in_item_t  in_item,
  input  wire logic                push,
  output logic                     full,
  output psrl_pkg::out_item_t      out_item,
  output logic                     empty,
  input  wire logic                pop,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import psrl_pkg::*;

  logic [8:0]  ring_size;
  logic        backtrace_on;
  logic [63:0] escape_value;
  logic [7:0]  trace_begin_code, profiled_mask, active_mask, present_mask;
  task_t       q_task;
  logic        q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // Hold configuration registers; write one per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size        <= 9'd256;
      backtrace_on     <= 1'b0;
      escape_value     <= '1;
      trace_begin_code <= 8'd1;
      profiled_mask    <= 8'd0;
      active_mask      <= 8'd0;
      present_mask     <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RING_SIZE:  ring_size        <= cfg_data[8:0];
        REG_BACKTRACE:  backtrace_on     <= cfg_data[0];
        REG_ESCAPE:     escape_value     <= cfg_data;
        REG_BEGIN_CODE: trace_begin_code <= cfg_data[7:0];
        REG_PROFILED:   profiled_mask    <= cfg_data[7:0];
        REG_ACTIVE:     active_mask      <= cfg_data[7:0];
        REG_PRESENT:    present_mask     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  psrl_front #(.NUM_BUFFERS(NUM_BUFFERS)) u_front (
    .clk, .rst, .in_item, .in_push(push), .in_full(full),
    .escape_value, .profiled_mask, .active_mask, .present_mask,
    .q_task, .q_valid, .q_pop
  );

  psrl_back #(.NUM_BUFFERS(NUM_BUFFERS), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk, .rst, .q_task, .q_valid, .q_pop,
    .ring_size, .backtrace_on, .escape_value, .trace_begin_code,
    .out_item, .out_empty(empty), .out_pop(pop)
  );

  a_full_no_pop: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_pop || q_valid) else $error("queue full without entries");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(out_item)) else $error("result dropped");
  a_written: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.entries_written != 2'd3) else $error("bad write count");

endmodule
`default_nettype wire

[verif/ring_logger_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_logger_checker: result predictor and scoreboard of the ring logger
// Watches the config, input and result channels, predicts each command's
// result from its own copy of rings, counters and registers, and compares.
// ----------------------------------------------------------------------------
module ring_logger_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire psrl_pkg::in_item_t  in_item,
  input  wire logic                push,
  input  wire logic                full,
  input  wire psrl_pkg::out_item_t out_item,
  input  wire logic                empty,
  input  wire logic                pop,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  output logic [2047:0]            filled,
  output int                       pending,
  output int                       fail_count
);
  import psrl_pkg::*;

  localparam int DEPTH = 256;

  logic [8:0]  ring_size;
  logic        backtrace_on;
  logic [63:0] escape_value;
  logic [7:0]  begin_code;
  logic [7:0]  profiled_mask;
  logic [7:0]  active_mask;
  logic [7:0]  present_mask;

  logic [7:0]  head [8];
  logic [7:0]  tail [8];
  logic [63:0] pc_mem [2048];
  logic [9:0]  mode_event_mem [2048];
  logic [63:0] global_cnt [8];
  logic [31:0] buffer_cnt [32];

  out_item_t expected_results [$];

  function automatic int eff_size();
    return (ring_size > DEPTH) ? DEPTH : int'(ring_size);
  endfunction

  function automatic int free_slots(int b);
    int h;
    int t;
    h = head[b];
    t = tail[b];
    return ((t > h) ? 0 : eff_size()) + t - h - 1;
  endfunction

  function automatic void count_lost(int b);
    buffer_cnt[b * 4] += 1;
    global_cnt[G_LOST] += 1;
  endfunction

  function automatic logic [2:0] ring_write(int b, logic [63:0] pc, logic [1:0] mode,
                                            logic [7:0] ev);
    int h;
    h = head[b];
    if (h >= eff_size() || int'(tail[b]) >= eff_size()) begin
      global_cnt[G_CORRUPT] += 1;
      return ST_CORRUPT;
    end
    if (free_slots(b) <= 0) begin
      count_lost(b);
      return ST_LOST;
    end
    pc_mem[b * DEPTH + h] = pc;
    mode_event_mem[b * DEPTH + h] = {mode, ev};
    filled[b * DEPTH + h] = 1'b1;
    h++;
    if (h >= eff_size()) h = 0;
    head[b] = h[7:0];
    return ST_STORED;
  endfunction

  // Apply one command to the model state and return its result.
  function automatic out_item_t log_command(in_item_t it);
    out_item_t o;
    int b;
    logic go;
    o = '0;
    o.status = ST_DONE;
    b = it.buffer_sel;
    case (it.command)
      CMD_LOG: begin
        global_cnt[G_TOTAL] += 1;
        if (!profiled_mask[b]) begin
          global_cnt[G_OTHERS] += 1;
          o.status = ST_UNPROF;
        end else if (!present_mask[b]) begin
          global_cnt[G_INVALID] += 1;
          o.status = ST_NOBUF;
        end else begin
          go = 1'b1;
          if (backtrace_on) begin
            if (free_slots(b) < 2) begin
              count_lost(b);
              o.status = ST_LOST;
              go = 1'b0;
            end else begin
              o.status = ring_write(b, escape_value, it.sample_mode, begin_code);
              if (o.status != ST_STORED) begin
                count_lost(b);
                go = 1'b0;
              end else begin
                o.entries_written = 2'd1;
              end
            end
          end
          if (go) begin
            o.status = ring_write(b, it.sample_pc, it.sample_mode, it.sample_event);
            if (o.status == ST_STORED) begin
              o.entries_written += 2'd1;
              if (active_mask[b]) global_cnt[G_ACTIVE] += 1;
              else global_cnt[G_PASSIVE] += 1;
              if (it.sample_mode == 2'd0) buffer_cnt[b * 4 + 1] += 1;
              else if (it.sample_mode == 2'd1) buffer_cnt[b * 4 + 2] += 1;
              else buffer_cnt[b * 4 + 3] += 1;
            end
          end
        end
      end
      CMD_TRACE: begin
        if (it.sample_pc == escape_value) begin
          global_cnt[G_INVALID] += 1;
          o.status = ST_BADPC;
        end else if (!present_mask[b]) begin
          global_cnt[G_INVALID] += 1;
          o.status = ST_NOBUF;
        end else begin
          o.status = ring_write(b, it.sample_pc, it.sample_mode, 8'd0);
          if (o.status == ST_STORED) o.entries_written = 2'd1;
        end
      end
      CMD_TAIL: tail[b] = it.tail_value;
      CMD_READ: begin
        o.read_pc = pc_mem[b * DEPTH + it.entry_index];
        {o.read_mode, o.read_event} = mode_event_mem[b * DEPTH + it.entry_index];
      end
      CMD_STAT: begin
        if (it.stat_select < 4'd8) o.stat_value = global_cnt[it.stat_select[2:0]];
        else if (it.stat_select < 4'd12)
          o.stat_value = {32'd0, buffer_cnt[b * 4 + int'(it.stat_select) - 8]};
      end
      CMD_RESET: begin
        head[b] = '0;
        tail[b] = '0;
      end
      CMD_CLEAR: for (int i = 0; i < 8; i++) global_cnt[i] = '0;
      default: ;
    endcase
    o.head_now = head[b];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      ring_size     <= 9'd256;
      backtrace_on  <= 1'b0;
      escape_value  <= '1;
      begin_code    <= 8'd1;
      profiled_mask <= '0;
      active_mask   <= '0;
      present_mask  <= '0;
      for (int i = 0; i < 8; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        global_cnt[i] <= '0;
      end
      for (int i = 0; i < 32; i++) buffer_cnt[i] <= '0;
      filled <= '0;
      expected_results.delete();
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RING_SIZE:  ring_size     <= cfg_data[8:0];
          REG_BACKTRACE:  backtrace_on  <= cfg_data[0];
          REG_ESCAPE:     escape_value  <= cfg_data;
          REG_BEGIN_CODE: begin_code    <= cfg_data[7:0];
          REG_PROFILED:   profiled_mask <= cfg_data[7:0];
          REG_ACTIVE:     active_mask   <= cfg_data[7:0];
          REG_PRESENT:    present_mask  <= cfg_data[7:0];
          default: ;
        endcase
      end
      // Compare the result transfer first; a same-edge input cannot produce it.
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report("result with nothing expected", 64'd1, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status) report("status", out_item.status, want.status);
          if (out_item.entries_written !== want.entries_written)
            report("entries_written", out_item.entries_written, want.entries_written);
          if (out_item.head_now !== want.head_now)
            report("head_now", out_item.head_now, want.head_now);
          if (out_item.read_pc !== want.read_pc)
            report("read_pc", out_item.read_pc, want.read_pc);
          if (out_item.read_mode !== want.read_mode)
            report("read_mode", out_item.read_mode, want.read_mode);
          if (out_item.read_event !== want.read_event)
            report("read_event", out_item.read_event, want.read_event);
          if (out_item.stat_value !== want.stat_value)
            report("stat_value", out_item.stat_value, want.stat_value);
        end
      end
      if (push && !full) expected_results.push_back(log_command(in_item));
      pending <= expected_results.size();
    end
  end

endmodule

[verif/tb_profile_sample_ring_logger.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_profile_sample_ring_logger: testbench of the profiling sample ring logger
// Directed commands over every status, then phases of random commands under
// changing register settings, with random stalls on both queue sides.
// ----------------------------------------------------------------------------
module tb_profile_sample_ring_logger;
  import psrl_pkg::*;

  localparam int PHASE_ITEMS = 210;
  localparam int NUM_PHASES  = 8;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst;
  in_item_t    in_item;
  logic        push;
  logic        full;
  out_item_t   out_item;
  logic        empty;
  logic        pop;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  logic [2047:0] filled;
  int          pending;
  int          fail_count;

  // Stimulus-side copy of the settings that shape well-formed commands.
  int          ring_sz = 256;
  logic [63:0] escape  = '1;
  int          sent = 0;
  logic        calm = 1'b0;
  int          quiet_cycles = 0;
  int          pop_hold = 0;

  profile_sample_ring_logger i_dut (
    .clk, .rst, .in_item, .push, .full, .out_item, .empty, .pop,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ring_logger_checker i_checker (
    .clk, .rst, .in_item, .push, .full, .out_item, .empty, .pop,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .filled, .pending, .fail_count
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Result side: stall in random bursts, none once the run turns calm.
  always @(negedge clk) begin
    if (rst || calm) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pop_hold <= $urandom_range(0, 13);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold the item until the queue takes it; optionally idle before it.
  task automatic send(in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Drain all results, let the back end settle, then write one register.
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_RING_SIZE) ring_sz = (data[8:0] > 9'd256) ? 256 : int'(data[8:0]);
    if (idx == REG_ESCAPE) escape = data;
  endtask

  function automatic in_item_t make_cmd(logic [2:0] cmd, logic [2:0] b, logic [63:0] pc);
    in_item_t it;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    it.command = cmd;
    it.buffer_sel = b;
    it.sample_pc = pc;
    return it;
  endfunction

  // Pick a written entry of the buffer; fall back to a counter read.
  function automatic in_item_t make_read(logic [2:0] b);
    in_item_t it;
    int idx;
    it = make_cmd(CMD_STAT, b, {$urandom, $urandom});
    for (int k = 0; k < 24; k++) begin
      idx = (ring_sz >= 1 && k < 20) ? $urandom_range(0, ring_sz - 1) : $urandom_range(0, 255);
      if (filled[b * 256 + idx]) begin
        it.command = CMD_READ;
        it.entry_index = idx[7:0];
        return it;
      end
    end
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t it;
    int pick;
    logic [2:0] b;
    logic [63:0] pc;
    pick = $urandom_range(0, 99);
    b = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: pc = '0;
      1: pc = '1;
      2: pc = escape;
      default: pc = {$urandom, $urandom};
    endcase
    if (pick < 45) it = make_cmd(CMD_LOG, b, pc);
    else if (pick < 60) it = make_cmd(CMD_TRACE, b, pc);
    else if (pick < 75) begin
      it = make_cmd(CMD_TAIL, b, pc);
      // Mostly a legal tail that frees room; now and then a random one that may corrupt.
      if (ring_sz >= 1 && $urandom_range(0, 9) != 0)
        it.tail_value = 8'($urandom_range(0, ring_sz - 1));
    end else if (pick < 85) it = make_read(b);
    else if (pick < 95) it = make_cmd(CMD_STAT, b, pc);
    else if (pick < 97) it = make_cmd(CMD_RESET, b, pc);
    else if (pick < 99) it = make_cmd(CMD_CLEAR, b, pc);
    else it = make_cmd(3'd7, b, pc);
    return it;
  endfunction

  task automatic setup(int sz, logic bt, logic [63:0] esc, logic [7:0] code,
                       logic [7:0] prof, logic [7:0] act, logic [7:0] pres);
    write_reg(REG_RING_SIZE, 64'(sz));
    write_reg(REG_BACKTRACE, 64'(bt));
    write_reg(REG_ESCAPE, esc);
    write_reg(REG_BEGIN_CODE, 64'(code));
    write_reg(REG_PROFILED, 64'(prof));
    write_reg(REG_ACTIVE, 64'(act));
    write_reg(REG_PRESENT, 64'(pres));
  endtask

  initial begin
    in_item_t it;
    int sizes [NUM_PHASES];
    sizes = '{3, 256, 2, 511, 0, 17, 1, 5};
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed: four-entry rings, backtrace on, buffer 6 profiled but absent,
    // buffer 7 unprofiled.
    setup(4, 1'b1, 64'h0123_4567_89AB_CDEF, 8'hFF, 8'h7F, 8'h55, 8'hBF);
    send(make_cmd(CMD_LOG, 3'd7, '1));
    send(make_cmd(CMD_LOG, 3'd6, '0));
    it = make_cmd(CMD_LOG, 3'd0, '1);
    it.sample_mode = 2'd3;
    it.sample_event = 8'hFF;
    send(it);
    send(make_cmd(CMD_LOG, 3'd0, '0));         // only one slot left: lost
    it = make_cmd(CMD_TAIL, 3'd0, '0);
    it.tail_value = 8'd2;
    send(it);
    it = make_cmd(CMD_READ, 3'd0, '0);
    it.entry_index = 8'd0;
    send(it);
    it.entry_index = 8'd1;
    send(it);
    send(make_cmd(CMD_TRACE, 3'd1, 64'h0123_4567_89AB_CDEF));  // escape pc
    send(make_cmd(CMD_TRACE, 3'd6, '0));       // absent buffer
    it = make_cmd(CMD_TAIL, 3'd1, '0);
    it.tail_value = 8'hFF;                     // beyond the ring: corrupted
    send(it);
    send(make_cmd(CMD_LOG, 3'd1, '0));
    send(make_cmd(CMD_TRACE, 3'd1, '0));
    send(make_cmd(CMD_RESET, 3'd1, '0));
    send(make_cmd(CMD_TRACE, 3'd1, '1));
    for (int s = 0; s < 16; s += 3) begin
      it = make_cmd(CMD_STAT, 3'd0, '0);
      it.stat_select = s[3:0];
      send(it);
    end
    send(make_cmd(CMD_CLEAR, 3'd0, '0));
    send(make_cmd(3'd7, 3'd2, '0));

    // Random phases, each under a fresh register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: setup(sizes[p], 1'b0, '1, 8'd0, 8'hFF, 8'h00, 8'hFF);
        1: setup(sizes[p], 1'b1, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default:
          setup(sizes[p], p[0], {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                8'hFF & ~(8'd1 << $urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                8'hFF & ~(8'd1 << $urandom_range(0, 7)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == NUM_PHASES - 1 && n > PHASE_ITEMS / 2) calm = 1'b1;
        send(random_cmd());
      end
    end
    push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/psrl_pkg.sv
hw/rtl/psrl_front.sv
hw/rtl/psrl_back.sv
hw/rtl/profile_sample_ring_logger.sv
verif/ring_logger_checker.sv
verif/tb_profile_sample_ring_logger.sv
